[rtl/core/qrs_pkg.sv]
`timescale 1ns / 1ps
// Package for the quadratic root solver: status codes and the word types
// on the command and result ports. No dependencies.
package qrs_pkg;

  typedef enum logic [2:0] {
    STAT_TAUT  = 3'd0,
    STAT_NONE  = 3'd1,
    STAT_FIRST = 3'd2,
    STAT_POS   = 3'd3,
    STAT_ZERO  = 3'd4,
    STAT_NEG   = 3'd5,
    STAT_OVER  = 3'd6
  } status_e;

  typedef struct packed {
    logic signed [31:0] coef_a;
    logic signed [31:0] coef_b;
    logic signed [31:0] coef_c;
    logic        [3:0]  poly_degree;
  } eq_word_t;

  typedef struct packed {
    status_e            status;
    logic signed [63:0] disc;
    logic signed [31:0] root0_re;
    logic signed [31:0] root0_im;
    logic signed [31:0] root1_re;
    logic signed [31:0] root1_im;
  } root_word_t;

endpackage

[rtl/core/quadratic_root_solver.sv]
`timescale 1ns / 1ps
// Quadratic root solver top level: a fully pipelined discriminant, square root
// and divider datapath. Depends on qrs_pkg.
//
// One equation word enters per clock whenever start is high; busy stays low,
// because every stage advances every cycle and the result side is never held
// off. Each word comes out on res_o, flagged by done_o for a single cycle, in
// order. The pipeline runs through the multiplier, discriminant and status
// stages, the 32-step square root (one result bit per stage), the numerator and
// magnitude stages, the 50-step restoring divider (one quotient bit per stage
// for the Q16.16 quotient of a numerator scaled by 2^16) and the output stage.
// The three quotients (first root, second root, imaginary part) run in three
// parallel divider lanes sharing one denominator. Roots that the status does
// not use read as zero.
module quadratic_root_solver (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  qrs_pkg::eq_word_t    eq_i,
  output logic                 done_o,
  output qrs_pkg::root_word_t  res_o
);

  localparam int SQRT_STEPS = 32;
  localparam int DIV_W      = 50;
  localparam int LATENCY    = 3 + SQRT_STEPS + 2 + DIV_W + 1;

  typedef struct packed {
    qrs_pkg::status_e   status;
    logic signed [63:0] disc;
    logic signed [33:0] den;
    logic signed [32:0] nb;
  } side_t;

  typedef struct packed {
    qrs_pkg::status_e   status;
    logic signed [63:0] disc;
    logic               neg0;
    logic               neg1;
    logic               neg2;
    logic        [32:0] dabs;
  } dcarry_t;

  function automatic logic signed [31:0] sat_q(input logic [DIV_W-1:0] q, input logic neg);
    logic signed [31:0] r;
    if (neg) begin
      if (q > DIV_W'(64'd2147483648)) r = 32'sh8000_0000;
      else                            r = -$signed(q[31:0]);
    end else begin
      if (q > DIV_W'(64'd2147483647)) r = 32'sh7fff_ffff;
      else                            r = $signed(q[31:0]);
    end
    return r;
  endfunction

  logic take;
  assign busy = 1'b0;
  assign take = start && !busy;

  // stage 1: products
  logic               v1_q;
  qrs_pkg::eq_word_t  e1_q;
  logic signed [63:0] bb1_q, ac1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else         v1_q <= take;
  end

  always_ff @(posedge clk_i) begin
    e1_q  <= eq_i;
    bb1_q <= 64'(eq_i.coef_b) * 64'(eq_i.coef_b);
    ac1_q <= 64'(eq_i.coef_a) * 64'(eq_i.coef_c);
  end

  // stage 2: b*b - 4ac, saturated (exact value needs 66 bits)
  logic               v2_q;
  qrs_pkg::eq_word_t  e2_q;
  logic signed [63:0] disc2_d, disc2_q;
  logic signed [65:0] disc_full;

  assign disc_full = {{2{bb1_q[63]}}, bb1_q} - {ac1_q, 2'b00};

  always_comb begin
    if (disc_full[65:63] == 3'b000 || disc_full[65:63] == 3'b111) begin
      disc2_d = disc_full[63:0];
    end else if (disc_full[65]) begin
      disc2_d = {1'b1, 63'd0};
    end else begin
      disc2_d = {1'b0, {63{1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else         v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    e2_q    <= e1_q;
    disc2_q <= disc2_d;
  end

  // stage 3: status, root operand, denominator, negated numerator base
  qrs_pkg::status_e status3;
  side_t            side3;
  logic      [63:0] mag3;

  always_comb begin
    if (e2_q.poly_degree == 4'd0) begin
      status3 = (e2_q.coef_c == 32'sd0) ? qrs_pkg::STAT_TAUT : qrs_pkg::STAT_NONE;
    end else if (e2_q.poly_degree == 4'd1) begin
      if (e2_q.coef_b != 32'sd0)       status3 = qrs_pkg::STAT_FIRST;
      else if (e2_q.coef_c == 32'sd0)  status3 = qrs_pkg::STAT_TAUT;
      else                             status3 = qrs_pkg::STAT_NONE;
    end else if (e2_q.poly_degree == 4'd2) begin
      if (e2_q.coef_a == 32'sd0)       status3 = qrs_pkg::STAT_TAUT;
      else if (disc2_q[63])            status3 = qrs_pkg::STAT_NEG;
      else if (disc2_q == 64'sd0)      status3 = qrs_pkg::STAT_ZERO;
      else                             status3 = qrs_pkg::STAT_POS;
    end else begin
      status3 = qrs_pkg::STAT_OVER;
    end
  end

  always_comb begin
    side3.status = status3;
    side3.disc   = disc2_q;
    if (e2_q.poly_degree == 4'd1) begin
      side3.den = {{2{e2_q.coef_b[31]}}, e2_q.coef_b};
      side3.nb  = -{e2_q.coef_c[31], e2_q.coef_c};
    end else begin
      side3.den = {e2_q.coef_a[31], e2_q.coef_a, 1'b0};
      side3.nb  = -{e2_q.coef_b[31], e2_q.coef_b};
    end
    mag3 = disc2_q[63] ? (64'd0 - 64'(disc2_q)) : 64'(disc2_q);
  end

  // square root pipeline, element 0 is the stage-3 register
  logic        sq_v_q    [SQRT_STEPS+1];
  side_t       sq_side_q [SQRT_STEPS+1];
  logic [63:0] sq_x_q    [SQRT_STEPS+1];
  logic [33:0] sq_rem_q  [SQRT_STEPS+1];
  logic [31:0] sq_root_q [SQRT_STEPS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sq_v_q[0] <= 1'b0;
    else         sq_v_q[0] <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    sq_side_q[0] <= side3;
    sq_x_q[0]    <= mag3;
    sq_rem_q[0]  <= '0;
    sq_root_q[0] <= '0;
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    logic [35:0] rsh, trial;
    logic        ge;

    assign rsh   = {sq_rem_q[k], sq_x_q[k][63-2*k -: 2]};
    assign trial = {2'b00, sq_root_q[k], 2'b01};
    assign ge    = rsh >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sq_v_q[k+1] <= 1'b0;
      else         sq_v_q[k+1] <= sq_v_q[k];
    end

    always_ff @(posedge clk_i) begin
      sq_side_q[k+1] <= sq_side_q[k];
      sq_x_q[k+1]    <= sq_x_q[k];
      sq_rem_q[k+1]  <= ge ? 34'(rsh - trial) : rsh[33:0];
      sq_root_q[k+1] <= {sq_root_q[k][30:0], ge};
    end
  end

  // numerators: -b -/+ s for two real roots, else the base alone
  logic               vn1_q;
  side_t              sn1_q;
  logic signed [34:0] num0_q, num1_q;
  logic        [31:0] sroot_q;
  logic signed [34:0] nb_ext, s_ext;

  assign nb_ext = {{2{sq_side_q[SQRT_STEPS].nb[32]}}, sq_side_q[SQRT_STEPS].nb};
  assign s_ext  = {3'b000, sq_root_q[SQRT_STEPS]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vn1_q <= 1'b0;
    else         vn1_q <= sq_v_q[SQRT_STEPS];
  end

  always_ff @(posedge clk_i) begin
    sn1_q   <= sq_side_q[SQRT_STEPS];
    sroot_q <= sq_root_q[SQRT_STEPS];
    if (sq_side_q[SQRT_STEPS].status == qrs_pkg::STAT_POS) begin
      num0_q <= nb_ext - s_ext;
      num1_q <= nb_ext + s_ext;
    end else begin
      num0_q <= nb_ext;
      num1_q <= nb_ext;
    end
  end

  // divider pipeline, element 0 holds magnitudes and signs
  logic             dv_v_q [DIV_W+1];
  dcarry_t          dv_c_q [DIV_W+1];
  logic [DIV_W-1:0] dv_n_q [DIV_W+1][3];
  logic [32:0]      dv_r_q [DIV_W+1][3];
  logic [DIV_W-1:0] dv_q_q [DIV_W+1][3];

  logic [33:0] mag0, mag1;
  dcarry_t     c0;

  always_comb begin
    mag0      = num0_q[34] ? 34'(-num0_q) : 34'(num0_q);
    mag1      = num1_q[34] ? 34'(-num1_q) : 34'(num1_q);
    c0.status = sn1_q.status;
    c0.disc   = sn1_q.disc;
    c0.neg0   = num0_q[34] ^ sn1_q.den[33];
    c0.neg1   = num1_q[34] ^ sn1_q.den[33];
    c0.neg2   = sn1_q.den[33];
    c0.dabs   = sn1_q.den[33] ? 33'(-sn1_q.den) : 33'(sn1_q.den);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dv_v_q[0] <= 1'b0;
    else         dv_v_q[0] <= vn1_q;
  end

  always_ff @(posedge clk_i) begin
    dv_c_q[0]    <= c0;
    dv_n_q[0][0] <= {mag0, 16'd0};
    dv_n_q[0][1] <= {mag1, 16'd0};
    dv_n_q[0][2] <= {2'b00, sroot_q, 16'd0};
    for (int l = 0; l < 3; l++) begin
      dv_r_q[0][l] <= '0;
      dv_q_q[0][l] <= '0;
    end
  end

  for (genvar k = 0; k < DIV_W; k++) begin : g_div
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_v_q[k+1] <= 1'b0;
      else         dv_v_q[k+1] <= dv_v_q[k];
    end

    always_ff @(posedge clk_i) begin
      dv_c_q[k+1] <= dv_c_q[k];
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [33:0] rsh, dext;
      logic        ge;

      assign rsh  = {dv_r_q[k][l], dv_n_q[k][l][DIV_W-1-k]};
      assign dext = {1'b0, dv_c_q[k].dabs};
      assign ge   = rsh >= dext;

      always_ff @(posedge clk_i) begin
        dv_n_q[k+1][l] <= dv_n_q[k][l];
        dv_r_q[k+1][l] <= ge ? 33'(rsh - dext) : rsh[32:0];
        dv_q_q[k+1][l] <= {dv_q_q[k][l][DIV_W-2:0], ge};
      end
    end
  end

  // output: sign, saturate, zero the unused roots
  logic                done_q;
  qrs_pkg::root_word_t res_d, res_q;
  logic signed [31:0]  q0, q1, im0, im1;
  dcarry_t             cl;

  always_comb begin
    cl  = dv_c_q[DIV_W];
    q0  = sat_q(dv_q_q[DIV_W][0], cl.neg0);
    q1  = sat_q(dv_q_q[DIV_W][1], cl.neg1);
    im0 = sat_q(dv_q_q[DIV_W][2], cl.neg2);
    im1 = sat_q(dv_q_q[DIV_W][2], !cl.neg2);
    res_d.status   = cl.status;
    res_d.disc     = cl.disc;
    res_d.root0_re = '0;
    res_d.root0_im = '0;
    res_d.root1_re = '0;
    res_d.root1_im = '0;
    unique case (cl.status)
      qrs_pkg::STAT_FIRST, qrs_pkg::STAT_ZERO: begin
        res_d.root0_re = q0;
      end
      qrs_pkg::STAT_POS: begin
        res_d.root0_re = q0;
        res_d.root1_re = q1;
      end
      qrs_pkg::STAT_NEG: begin
        res_d.root0_re = q0;
        res_d.root1_re = q1;
        res_d.root0_im = im0;
        res_d.root1_im = im1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= dv_v_q[DIV_W];
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  // every accepted word comes out after the fixed pipeline depth
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LATENCY done_o)
    else $error("result word missing after pipeline latency");

  // imaginary parts only for a conjugate pair
  a_im_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.status != qrs_pkg::STAT_NEG) |->
    (res_o.root0_im == 32'sd0 && res_o.root1_im == 32'sd0))
    else $error("nonzero imaginary part outside conjugate case");

  // a conjugate pair shares its real part
  a_pair_re: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.status == qrs_pkg::STAT_NEG) |-> (res_o.root0_re == res_o.root1_re))
    else $error("conjugate roots differ in real part");

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// Self-checking bench for quadratic_root_solver: directed equations, then random
// ones, compared field by field to typed-in words or a root predictor. Uses qrs_pkg.
module testbench;

  localparam int ONE      = 65536;   // 1.0 in Q16.16
  localparam int N_RANDOM = 1830;
  localparam int TAIL     = 120;     // cycles past the last word, above the latency

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  qrs_pkg::eq_word_t   eq_i = '0;
  logic                done_o;
  qrs_pkg::root_word_t res_o;

  // Directed table row: expected word typed in only where has_known is set.
  typedef struct {
    qrs_pkg::eq_word_t   eq;
    bit                  has_known;
    qrs_pkg::root_word_t known;
  } eq_row_t;

  qrs_pkg::root_word_t root_q[$];  // expected result words, oldest first
  int         n_errors = 0;
  int         n_sent = 0;
  int         n_checked = 0;
  int         status_seen[7];
  bit         no_gaps = 1'b0;

  always #5 clk_i = ~clk_i;

  quadratic_root_solver dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .eq_i   (eq_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  // Floor of the integer square root of a 64-bit magnitude, bit by bit.
  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r = 0;
    longint unsigned bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= r + bitv) begin
        x -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  // Q16.16 quotient of num scaled by 2^16, truncated toward zero, saturated.
  function automatic logic signed [31:0] quot_sat(longint num, longint den);
    longint q;
    q = (num * ONE) / den;
    if (q > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (q < -64'sd2147483648) return 32'sh80000000;
    return q[31:0];
  endfunction

  function automatic qrs_pkg::root_word_t solve_roots(qrs_pkg::eq_word_t w);
    qrs_pkg::root_word_t r;
    longint            a, b, c, dsc, s, den;
    logic signed [66:0] full, bb, ac;
    a = w.coef_a;
    b = w.coef_b;
    c = w.coef_c;
    r = '0;
    bb = b * b;
    ac = a * c;
    full = bb - (ac <<< 2);
    // saturate the exact discriminant to Q32.32
    if (full > 67'sd9223372036854775807) dsc = 64'sh7FFFFFFFFFFFFFFF;
    else if (full < -67'sd9223372036854775808) dsc = 64'sh8000000000000000;
    else dsc = full[63:0];
    r.disc = dsc;
    case (w.poly_degree)
      4'd0: r.status = (c == 0) ? qrs_pkg::STAT_TAUT : qrs_pkg::STAT_NONE;
      4'd1: begin
        if (b != 0) begin
          r.status   = qrs_pkg::STAT_FIRST;
          r.root0_re = quot_sat(-c, b);
        end else begin
          r.status = (c == 0) ? qrs_pkg::STAT_TAUT : qrs_pkg::STAT_NONE;
        end
      end
      4'd2: begin
        if (a == 0) begin
          r.status = qrs_pkg::STAT_TAUT;
        end else begin
          den = 2 * a;
          if (dsc > 0) begin
            s = int_sqrt(dsc);
            r.status   = qrs_pkg::STAT_POS;
            r.root0_re = quot_sat(-b - s, den);
            r.root1_re = quot_sat(-b + s, den);
          end else if (dsc == 0) begin
            r.status   = qrs_pkg::STAT_ZERO;
            r.root0_re = quot_sat(-b, den);
          end else begin
            // magnitude of the most negative value is 2^63, fine unsigned
            s = int_sqrt(64'd0 - dsc);
            r.status   = qrs_pkg::STAT_NEG;
            r.root0_re = quot_sat(-b, den);
            r.root1_re = r.root0_re;
            r.root0_im = quot_sat(s, den);
            r.root1_im = quot_sat(-s, den);
          end
        end
      end
      default: r.status = qrs_pkg::STAT_OVER;
    endcase
    return r;
  endfunction

  // Present one word after a random gap (none if no_gaps); return once it is taken.
  task automatic send_eq(qrs_pkg::eq_word_t w, bit has_known, qrs_pkg::root_word_t known);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 14);
    repeat (gap) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    eq_i  <= w;
    do @(posedge clk_i); while (!(start && !busy));
    root_q.push_back(has_known ? known : solve_roots(w));
    n_sent++;
  endtask

  // Build from integer roots: well-formed cases on the positive and zero branches.
  function automatic qrs_pkg::eq_word_t from_roots(int k, int r1, int r2);
    qrs_pkg::eq_word_t w;
    w.coef_a = k * ONE;
    w.coef_b = -k * (r1 + r2) * ONE;
    w.coef_c = k * r1 * r2 * ONE;
    w.poly_degree = 4'd2;
    return w;
  endfunction

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 5))
      0:       return $urandom();
      1:       return 32'sd0;
      2:       return ($urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000);
      3:       return $signed($urandom_range(0, 40)) - 20;    // tiny fractions
      default: return ($signed($urandom_range(0, 200)) - 100) * ONE;
    endcase
  endfunction

  function automatic qrs_pkg::eq_word_t rand_eq();
    qrs_pkg::eq_word_t w;
    int       p;
    p = $urandom_range(0, 9);
    if (p < 4) begin
      w = from_roots($signed($urandom_range(1, 8)) * ($urandom_range(0, 1) ? 1 : -1),
                     $signed($urandom_range(0, 40)) - 20,
                     $signed($urandom_range(0, 40)) - 20);
      // equal roots give a zero discriminant
      if ($urandom_range(0, 3) == 0) w = from_roots(2, 3, 3);
    end else begin
      w.coef_a = rand_coef();
      w.coef_b = rand_coef();
      w.coef_c = rand_coef();
      w.poly_degree = (p == 9) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 3));
    end
    return w;
  endfunction

  // Result side: every strobed word must match the oldest expectation.
  always @(posedge clk_i) begin
    qrs_pkg::root_word_t e;
    if (rst_ni && done_o) begin
      if (root_q.size() == 0) begin
        $error("result word with none expected: status %0d", res_o.status);
        n_errors++;
      end else begin
        e = root_q.pop_front();
        n_checked++;
        status_seen[e.status]++;
        if (res_o.status !== e.status) begin
          $error("status: expected %0d, actual %0d", e.status, res_o.status);
          n_errors++;
        end
        if (res_o.disc !== e.disc) begin
          $error("disc: expected %0d, actual %0d", e.disc, res_o.disc);
          n_errors++;
        end
        if (res_o.root0_re !== e.root0_re) begin
          $error("root0_re: expected %0d, actual %0d", e.root0_re, res_o.root0_re);
          n_errors++;
        end
        if (res_o.root0_im !== e.root0_im) begin
          $error("root0_im: expected %0d, actual %0d", e.root0_im, res_o.root0_im);
          n_errors++;
        end
        if (res_o.root1_re !== e.root1_re) begin
          $error("root1_re: expected %0d, actual %0d", e.root1_re, res_o.root1_re);
          n_errors++;
        end
        if (res_o.root1_im !== e.root1_im) begin
          $error("root1_im: expected %0d, actual %0d", e.root1_im, res_o.root1_im);
          n_errors++;
        end
      end
    end
  end

  initial begin
    eq_row_t             rows[$];
    eq_row_t             row;
    qrs_pkg::root_word_t none;
    none = '0;

    // Hand-checked rows: trivial degrees, zero top coefficients, the over-degree code.
    row = '{'{32'sd0, 32'sd0, 32'sd0, 4'd0}, 1'b1,
            '{qrs_pkg::STAT_TAUT, 64'sd0, 0, 0, 0, 0}};
    rows.push_back(row);
    row = '{'{32'sd0, 32'sd0, ONE, 4'd0}, 1'b1,
            '{qrs_pkg::STAT_NONE, 64'sd0, 0, 0, 0, 0}};
    rows.push_back(row);
    row = '{'{32'sd0, 32'sd0, 32'sd0, 4'd1}, 1'b1,
            '{qrs_pkg::STAT_TAUT, 64'sd0, 0, 0, 0, 0}};
    rows.push_back(row);
    row = '{'{32'sd0, 32'sd0, 32'sh80000000, 4'd1}, 1'b1,
            '{qrs_pkg::STAT_NONE, 64'sd0, 0, 0, 0, 0}};
    rows.push_back(row);
    row = '{'{32'sd0, 32'sd0, ONE, 4'd2}, 1'b1,
            '{qrs_pkg::STAT_TAUT, 64'sd0, 0, 0, 0, 0}};
    rows.push_back(row);
    row = '{'{32'sd0, ONE, 32'sd0, 4'd3}, 1'b1,
            '{qrs_pkg::STAT_OVER, 64'sd4294967296, 0, 0, 0, 0}};
    rows.push_back(row);
    row = '{'{32'sd0, 32'sd0, 32'sd0, 4'd15}, 1'b1,
            '{qrs_pkg::STAT_OVER, 64'sd0, 0, 0, 0, 0}};
    rows.push_back(row);
    // Predicted rows: degree 1, each discriminant sign, saturation extremes, degree 8.
    row.has_known = 1'b0;
    row.known = none;
    row.eq = '{32'sd0, 2 * ONE, -3 * ONE, 4'd1};                        rows.push_back(row);
    row.eq = '{32'sd0, 32'sd1, 32'sh80000000, 4'd1};                     rows.push_back(row);
    row.eq = '{32'sd0, 32'sh80000000, 32'sh7FFFFFFF, 4'd1};              rows.push_back(row);
    row.eq = '{ONE, -3 * ONE, 2 * ONE, 4'd2};                            rows.push_back(row);
    row.eq = '{ONE, -2 * ONE, ONE, 4'd2};                                rows.push_back(row);
    row.eq = '{ONE, 32'sd0, ONE, 4'd2};                                  rows.push_back(row);
    row.eq = '{-ONE, ONE, 6 * ONE, 4'd2};                                rows.push_back(row);
    row.eq = '{32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 4'd2};       rows.push_back(row);
    row.eq = '{32'sh7FFFFFFF, 32'sd0, 32'sh7FFFFFFF, 4'd2};              rows.push_back(row);
    row.eq = '{32'sh80000000, 32'sh80000000, 32'sh80000000, 4'd2};       rows.push_back(row);
    row.eq = '{32'sd1, 32'sh7FFFFFFF, 32'sd0, 4'd2};                     rows.push_back(row);
    row.eq = '{32'sd1, 32'sd0, 32'sh80000000, 4'd2};                     rows.push_back(row);
    row.eq = '{32'shFFFFFFFF, 32'shFFFFFFFF, 32'shFFFFFFFF, 4'd2};       rows.push_back(row);
    row.eq = '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 4'd8};       rows.push_back(row);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_eq(rows[i].eq, rows[i].has_known, rows[i].known);

    for (int n = 0; n < N_RANDOM; n++) begin
      // alternate gapped stretches with back-to-back bursts
      if (n % 100 == 0) no_gaps = ($urandom_range(0, 2) == 0);
      if (n == N_RANDOM / 2) begin
        // drain the pipe completely once mid-run
        start <= 1'b0;
        wait (root_q.size() == 0);
        @(posedge clk_i);
      end
      send_eq(rand_eq(), 1'b0, none);
    end
    start <= 1'b0;

    wait (root_q.size() == 0);
    repeat (TAIL) @(posedge clk_i);

    $display("Sent %0d equations, checked %0d result words; by status:", n_sent, n_checked);
    $display("  taut %0d none %0d first %0d pos %0d zero %0d neg %0d over %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5], status_seen[6]);
    if (n_errors == 0 && root_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
